// ===== src/wdcu_pkg.sv =====
// Package for the wheel drive command unit.
// Holds the command and result types, the mode, LED and register codes and the
// fixed-point constants for the percent scaling. No dependencies.
package wdcu_pkg;

    // Default sizing of the wheel set.
    localparam int NUM_WHEELS_DEF = 4;
    localparam int COUNT_BITS_DEF = 32;

    // Field widths.
    localparam int MODE_W      = 3;
    localparam int WHEEL_W     = 3;
    localparam int SPEED_W     = 16;
    localparam int LIMIT_W     = 7;
    localparam int PERIOD_W    = 16;
    localparam int MASK_W      = 4;
    localparam int LED_W       = 2;
    localparam int WHEEL_OUT_W = 2;
    localparam int CNT_OUT_W   = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // At most this many results come out of one emergency stop.
    localparam int MAX_STOP_RESULTS = 4;

    // Command modes.
    localparam logic [MODE_W-1:0] MODE_SET_SPEED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODER   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ESTOP     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

    // Wheel LED codes.
    localparam logic [LED_W-1:0] LED_NONE    = 2'd0;
    localparam logic [LED_W-1:0] LED_STOPPED = 2'd1;
    localparam logic [LED_W-1:0] LED_FORWARD = 2'd2;
    localparam logic [LED_W-1:0] LED_RED     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 2'd2;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] MAX_SPEED_RST   = 7'd12;
    localparam logic [MASK_W-1:0]  INVERT_MASK_RST = 4'd10;

    // Percent scale and reciprocals for division by it.
    // Period / 100 for any 16-bit period: (p * QUOT_RECIP) >> QUOT_SHIFT.
    // Small products below 2^14 / 100: (x * FRAC_RECIP) >> FRAC_SHIFT.
    localparam int PCT_SCALE  = 100;
    localparam int QUOT_RECIP = 83887;
    localparam int QUOT_SHIFT = 23;
    localparam int FRAC_RECIP = 10486;
    localparam int FRAC_SHIFT = 20;
    localparam int QUOT_W     = 10;
    localparam int REM_W      = 7;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [WHEEL_W-1:0]        wheel_index;
        logic signed [SPEED_W-1:0] speed_request;
    } t_cmd;

    typedef struct packed {
        logic [WHEEL_OUT_W-1:0] wheel_out;
        logic                   accepted;
        logic [PERIOD_W-1:0]    pulse_width;
        logic                   dir_level;
        logic [LED_W-1:0]       wheel_led;
        logic [CNT_OUT_W-1:0]   encoder_count;
        logic                   stop_active;
        logic                   last;
    } t_res;

endpackage

// ===== src/wdcu_cmd_if.sv =====
// Command channel of the wheel drive command unit.
// Carries valid, ready and one command; depends on wdcu_pkg.
interface wdcu_cmd_if;
    import wdcu_pkg::*;

    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/wdcu_res_if.sv =====
// Result channel of the wheel drive command unit.
// Carries valid, ready and one result; depends on wdcu_pkg.
interface wdcu_res_if;
    import wdcu_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/wheel_drive_command_unit_core.sv =====
// Wheel drive command unit: a command transfer writes its result into the output
// register, where it shows in the next cycle. Throughput is one command per cycle
// while results are taken; an emergency stop yields min(NUM_WHEELS, 4) results, one
// per cycle while taken, and the command side is held off until the last is taken.
// Reset is synchronous and active low: it clears the stop latch, direction flags,
// pins and counters and loads the register defaults.
// Depends on wdcu_pkg, wdcu_cmd_if and wdcu_res_if.
module wheel_drive_command_unit_core #(
    parameter int NUM_WHEELS = wdcu_pkg::NUM_WHEELS_DEF,
    parameter int COUNT_BITS = wdcu_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wdcu_cmd_if.sink                         i_cmd,
    wdcu_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [wdcu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wdcu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wdcu_pkg::*;

    localparam int IDX_W  = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam int NSTOP  = (NUM_WHEELS < MAX_STOP_RESULTS) ? NUM_WHEELS : MAX_STOP_RESULTS;
    localparam int STOP_W = (NSTOP > 1) ? $clog2(NSTOP) : 1;

    // Configuration: the period is kept as quotient and remainder by 100.
    logic [QUOT_W-1:0]  r_period_q;
    logic [REM_W-1:0]   r_period_r;
    logic [LIMIT_W-1:0] r_max_speed;
    logic [MASK_W-1:0]  r_invert_mask;

    // Wheel state.
    logic                  r_stop_latch;
    logic                  r_reverse [NUM_WHEELS];
    logic                  r_dir_pin [NUM_WHEELS];
    logic [COUNT_BITS-1:0] r_count   [NUM_WHEELS];

    // Output register and emergency stop sequencing.
    t_res              r_res;
    logic              r_res_valid;
    logic              r_stop_busy;
    logic [STOP_W-1:0] r_stop_next;

    logic cmd_ready;
    logic cmd_fire;
    logic res_fire;

    function automatic logic [CNT_OUT_W-1:0] cnt_to_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[CNT_OUT_W-1:0];
    endfunction

    // Handshake: the output register frees up when it is empty or being drained.
    assign cmd_ready   = !r_stop_busy && (!r_res_valid || o_res.ready);
    assign cmd_fire    = i_cmd.valid && cmd_ready;
    assign res_fire    = r_res_valid && o_res.ready;
    assign i_cmd.ready = cmd_ready;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    // Split a written period into quotient and remainder by the percent scale.
    logic [32:0]          cfg_prod;
    logic [QUOT_W-1:0]    cfg_q;
    logic [REM_W-1:0]     cfg_r;
    assign cfg_prod = 33'(i_cfg_data) * 33'(QUOT_RECIP);
    assign cfg_q    = cfg_prod[QUOT_SHIFT +: QUOT_W];
    assign cfg_r    = REM_W'(i_cfg_data - 16'(cfg_q * 16'(PCT_SCALE)));

    // Wheel read port: the stop sequence, wheel 0 for a new stop, else the command's wheel.
    logic [WHEEL_W-1:0]    rd_wheel;
    logic                  rd_valid;
    logic [IDX_W-1:0]      rd_idx;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic                  cur_dir;
    logic                  cur_rev;

    always_comb begin
        if (r_stop_busy) begin
            rd_wheel = WHEEL_W'(r_stop_next);
        end else if (i_cmd.data.mode == MODE_ESTOP) begin
            rd_wheel = '0;
        end else begin
            rd_wheel = i_cmd.data.wheel_index;
        end
    end

    assign rd_valid = {1'b0, rd_wheel} < (WHEEL_W + 1)'(NUM_WHEELS);
    assign rd_idx   = rd_wheel[IDX_W-1:0];
    assign cur_cnt  = r_count[rd_idx];
    assign cur_dir  = r_dir_pin[rd_idx];
    assign cur_rev  = r_reverse[rd_idx];

    // Speed path: clamp, magnitude and pulse width = mag * q + (mag * r) / 100.
    logic signed [16:0]   req_s;
    logic signed [16:0]   lim_s;
    logic signed [16:0]   pct_s;
    logic signed [7:0]    pct;
    logic                 neg;
    logic [7:0]           abs8;
    logic [LIMIT_W-1:0]   mag;
    logic [16:0]          prod_q;
    logic [13:0]          frac_num;
    logic [27:0]          frac_prod;
    logic [REM_W-1:0]     frac;
    logic [17:0]          pw_sum;
    logic [PERIOD_W-1:0]  pw;
    logic                 inv;

    always_comb begin
        req_s = 17'($signed(i_cmd.data.speed_request));
        lim_s = $signed({10'd0, r_max_speed});
        if (req_s < -lim_s) begin
            pct_s = -lim_s;
        end else if (req_s > lim_s) begin
            pct_s = lim_s;
        end else begin
            pct_s = req_s;
        end
    end

    assign pct       = 8'(pct_s);
    assign neg       = pct < 0;
    assign abs8      = neg ? 8'(-pct) : 8'(pct);
    assign mag       = abs8[LIMIT_W-1:0];
    assign prod_q    = 17'(mag) * 17'(r_period_q);
    assign frac_num  = 14'(mag) * 14'(r_period_r);
    assign frac_prod = 28'(frac_num) * 28'(FRAC_RECIP);
    assign frac      = frac_prod[FRAC_SHIFT +: REM_W];
    assign pw_sum    = 18'(prod_q) + 18'(frac);
    assign pw        = (pw_sum > 18'(16'hFFFF)) ? 16'hFFFF : pw_sum[PERIOD_W-1:0];
    assign inv       = (rd_wheel < WHEEL_W'(MASK_W)) ? r_invert_mask[rd_wheel[1:0]] : 1'b0;

    // Command decode: result for the accepted command and the state it writes.
    t_res                  cmd_res;
    logic                  upd_rev;
    logic                  upd_dir;
    logic                  upd_cnt;
    logic [COUNT_BITS-1:0] cnt_val;

    assign cnt_val = cur_rev ? (cur_cnt - 1'b1) : (cur_cnt + 1'b1);

    always_comb begin
        upd_rev               = 1'b0;
        upd_dir               = 1'b0;
        upd_cnt               = 1'b0;
        cmd_res.wheel_out     = rd_wheel[WHEEL_OUT_W-1:0];
        cmd_res.accepted      = 1'b0;
        cmd_res.pulse_width   = '0;
        cmd_res.dir_level     = rd_valid && cur_dir;
        cmd_res.wheel_led     = LED_NONE;
        cmd_res.encoder_count = rd_valid ? cnt_to_out(cur_cnt) : '0;
        cmd_res.stop_active   = r_stop_latch;
        cmd_res.last          = 1'b1;
        case (i_cmd.data.mode)
            MODE_SET_SPEED: begin
                if (!r_stop_latch && rd_valid) begin
                    cmd_res.accepted = 1'b1;
                    upd_rev          = 1'b1;
                    if (pw == '0) begin
                        cmd_res.wheel_led = LED_STOPPED;
                    end else begin
                        upd_dir             = 1'b1;
                        cmd_res.pulse_width = pw;
                        cmd_res.dir_level   = neg ^ inv;
                        cmd_res.wheel_led   = neg ? LED_RED : LED_FORWARD;
                    end
                end
            end
            MODE_ENCODER: begin
                if (rd_valid) begin
                    cmd_res.accepted      = 1'b1;
                    upd_cnt               = 1'b1;
                    cmd_res.encoder_count = cnt_to_out(cnt_val);
                end
            end
            MODE_ESTOP: begin
                cmd_res.accepted    = 1'b1;
                cmd_res.wheel_led   = LED_STOPPED;
                cmd_res.stop_active = 1'b1;
                cmd_res.last        = (NSTOP == 1);
            end
            MODE_RELEASE: begin
                cmd_res.accepted    = r_stop_latch;
                cmd_res.stop_active = 1'b0;
            end
            MODE_READ: begin
                cmd_res.accepted = rd_valid;
            end
            default: begin
                cmd_res.accepted = 1'b0;
            end
        endcase
    end

    // Follow-on results of an emergency stop, one wheel per transfer.
    t_res burst_res;
    logic burst_last;

    assign burst_last = r_stop_next == STOP_W'(NSTOP - 1);

    always_comb begin
        burst_res.wheel_out     = rd_wheel[WHEEL_OUT_W-1:0];
        burst_res.accepted      = 1'b1;
        burst_res.pulse_width   = '0;
        burst_res.dir_level     = cur_dir;
        burst_res.wheel_led     = LED_STOPPED;
        burst_res.encoder_count = cnt_to_out(cur_cnt);
        burst_res.stop_active   = r_stop_latch;
        burst_res.last          = burst_last;
    end

    // Configuration, wheel state and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_q    <= '0;
            r_period_r    <= '0;
            r_max_speed   <= MAX_SPEED_RST;
            r_invert_mask <= INVERT_MASK_RST;
            r_stop_latch  <= 1'b0;
            r_res_valid   <= 1'b0;
            r_stop_busy   <= 1'b0;
            r_stop_next   <= '0;
            for (int w = 0; w < NUM_WHEELS; w++) begin
                r_reverse[w] <= 1'b0;
                r_dir_pin[w] <= 1'b0;
                r_count[w]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PWM_PERIOD: begin
                        r_period_q <= cfg_q;
                        r_period_r <= cfg_r;
                    end
                    CFG_MAX_SPEED: begin
                        r_max_speed <= i_cfg_data[LIMIT_W-1:0];
                    end
                    CFG_INVERT_MASK: begin
                        r_invert_mask <= i_cfg_data[MASK_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (cmd_fire) begin
                if (upd_rev) begin
                    r_reverse[rd_idx] <= neg;
                end
                if (upd_dir) begin
                    r_dir_pin[rd_idx] <= neg ^ inv;
                end
                if (upd_cnt) begin
                    r_count[rd_idx] <= cnt_val;
                end
                if (i_cmd.data.mode == MODE_ESTOP) begin
                    r_stop_latch <= 1'b1;
                    r_stop_busy  <= (NSTOP > 1);
                    r_stop_next  <= STOP_W'(1);
                    for (int w = 0; w < NUM_WHEELS; w++) begin
                        r_reverse[w] <= 1'b0;
                    end
                end else if (i_cmd.data.mode == MODE_RELEASE) begin
                    r_stop_latch <= 1'b0;
                end
            end

            // Output register occupancy and stop sequence advance.
            if (cmd_fire) begin
                r_res_valid <= 1'b1;
            end else if (res_fire) begin
                if (r_stop_busy) begin
                    r_stop_next <= STOP_W'(r_stop_next + 1'b1);
                    if (burst_last) begin
                        r_stop_busy <= 1'b0;
                    end
                end else begin
                    r_res_valid <= 1'b0;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_res <= cmd_res;
        end else if (res_fire && r_stop_busy) begin
            r_res <= burst_res;
        end
    end

endmodule
